[rtl/bloom_filter_double_hash_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef BLOOM_FILTER_DOUBLE_HASH_CORE_DEFINES_SVH
`define BLOOM_FILTER_DOUBLE_HASH_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define BF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfdh_pkg.sv]
package bfdh_pkg;
  localparam int FILTER_BITS = 1048576;
  localparam int MAX_HASHES  = 16;
  localparam int HASH_BITS   = 64;
  localparam int CAP_W       = 21;
  localparam int HCNT_W      = 5;
  localparam int CNT_W       = 21;

  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_HASH_COUNT = 1'b1;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // probe generator -> memory stage
  typedef struct packed {
    logic valid;
    logic last;
    logic func;
  } probe_ctl_t;
endpackage

[rtl/bfdh_mod.sv]
// Sequential restoring remainder: rem = num % den, one quotient bit a cycle.
module bfdh_mod #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DEN_W-1:0] rem
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  shreg;
  logic [DEN_W-1:0]  part;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    trial;

  assign trial = {part, shreg[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      part  <= '0;
      den_q <= den;
    end else if (busy) begin
      shreg <= {shreg[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) part <= DEN_W'(trial - {1'b0, den_q});
      else part <= trial[DEN_W-1:0];
    end
  end

  assign rem = part;
endmodule

[rtl/bfdh_store.sv]
// Bit store with read-modify-write; clearing pass after reset.
module bfdh_store #(
  parameter int FILTER_BITS = bfdh_pkg::FILTER_BITS,
  parameter int ADDR_W = $clog2(FILTER_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  output logic              clearing,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_bit,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr
);
  logic              mem [FILTER_BITS];
  logic [ADDR_W:0]   clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == (ADDR_W+1)'(FILTER_BITS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr[ADDR_W-1:0]] <= 1'b0;
    else if (wr_en) mem[wr_addr] <= 1'b1;
    if (rd_en) rd_bit <= mem[rd_addr];
  end
endmodule

[rtl/bloom_filter_double_hash_core.sv]
// Channel | Signals                                 | Direction
// in      | in_valid/in_ready, func, hash_value     | to block
// out     | out_valid/out_ready, present,           | from block
//         | set_bit_count                           |
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data| to block
//
// Each probe runs the bit-serial remainder unit, then a store read and update;
// an item makes hash_count probes, clamped to 1..MAX_HASHES.
// After reset a clearing pass zeroes the bit store;
// in_ready stays low during it, cfg writes are taken throughout.
// One item at a time; the result word sits in an output register while the
// next word may be accepted.
module bloom_filter_double_hash_core #(
  parameter int FILTER_BITS = bfdh_pkg::FILTER_BITS,
  parameter int MAX_HASHES  = bfdh_pkg::MAX_HASHES,
  parameter int HASH_BITS   = bfdh_pkg::HASH_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      func,
  input  logic [63:0]               hash_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      present,
  output logic [bfdh_pkg::CNT_W-1:0] set_bit_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_data
);
  localparam int ADDR_W = $clog2(FILTER_BITS);
  localparam int CAPR_W = $clog2(FILTER_BITS + 1);
  localparam int HALF   = HASH_BITS / 2;
  localparam int KW     = $clog2(MAX_HASHES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [bfdh_pkg::CAP_W-1:0]  capacity_bits;
  logic [bfdh_pkg::HCNT_W-1:0] hash_count;
  logic [CAPR_W-1:0]           cap_eff;
  logic [KW-1:0]               nh_eff;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bits <= bfdh_pkg::CAP_W'(1048576);
      hash_count    <= bfdh_pkg::HCNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        bfdh_pkg::REG_CAPACITY:   capacity_bits <= cfg_data[bfdh_pkg::CAP_W-1:0];
        bfdh_pkg::REG_HASH_COUNT: hash_count <= cfg_data[bfdh_pkg::HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate config to legal ranges
  always_comb begin
    if (capacity_bits == '0) cap_eff = CAPR_W'(1);
    else if (32'(capacity_bits) > 32'(FILTER_BITS)) cap_eff = CAPR_W'(FILTER_BITS);
    else cap_eff = CAPR_W'(capacity_bits);
    if (hash_count == '0) nh_eff = KW'(1);
    else if (32'(hash_count) > 32'(MAX_HASHES)) nh_eff = KW'(MAX_HASHES);
    else nh_eff = KW'(hash_count);
  end

  logic [2:0]           state;
  logic                 out_load;
  logic                 op;
  logic [HASH_BITS-1:0] lo_w;
  logic [HASH_BITS-1:0] probe;
  logic [KW-1:0]        k;
  logic [KW-1:0]        nh_q;
  logic [CAPR_W-1:0]    cap_q;
  logic                 all_set;
  logic [bfdh_pkg::CNT_W-1:0] ones;
  logic                 clearing;
  logic                 mod_start, mod_done;
  logic [CAPR_W-1:0]    rem;
  logic [ADDR_W-1:0]    pos;
  logic                 rd_bit, wr_en;
  logic [HALF-1:0]      hi_h, lo_h;

  assign hi_h = hash_value[HASH_BITS-1:HALF];
  assign lo_h = hash_value[HALF-1:0];

  bfdh_mod #(.NUM_W(HASH_BITS), .DEN_W(CAPR_W)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .num(probe), .den(cap_q),
    .done(mod_done), .rem(rem)
  );

  bfdh_store #(.FILTER_BITS(FILTER_BITS), .ADDR_W(ADDR_W)) u_store (
    .clk(clk), .rst(rst), .clearing(clearing),
    .rd_en(state == S_READ), .rd_addr(pos), .rd_bit(rd_bit),
    .wr_en(wr_en), .wr_addr(pos)
  );

  assign in_ready  = (state == S_IDLE) && !clearing;
  assign mod_start = (state == S_MOD);
  assign wr_en     = (state == S_UPD) && (op == bfdh_pkg::FUNC_ADD) && !rd_bit;
  // result register takes a new word when empty or being drained
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ones      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_MOD;
        S_MOD:  state <= S_WAIT;
        S_WAIT: if (mod_done) state <= S_READ;
        S_READ: state <= S_UPD;
        S_UPD: begin
          if (wr_en) ones <= ones + 1'b1;
          state <= (k == nh_q) ? S_OUT : S_MOD;
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        op      <= func;
        lo_w    <= {lo_h, lo_h};
        probe   <= {hi_h, hi_h} + {lo_h, lo_h};
        k       <= KW'(1);
        nh_q    <= nh_eff;
        cap_q   <= cap_eff;
        all_set <= 1'b1;
      end
      S_WAIT: if (mod_done) pos <= rem[ADDR_W-1:0];
      S_UPD: begin
        if (!rd_bit) all_set <= 1'b0;
        probe <= probe + lo_w;
        k     <= k + 1'b1;
      end
      S_OUT: if (out_load) begin
        present       <= (op == bfdh_pkg::FUNC_LOOKUP) && all_set;
        set_bit_count <= ones;
      end
      default: ;
    endcase
  end
endmodule

[rtl/bfdh_checker.sv]
`include "bloom_filter_double_hash_core_defines.svh"
module bfdh_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic present,
  input logic [20:0] set_bit_count
);
  `BF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(set_bit_count) && $stable(present), "result word changed while stalled")
  `BF_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && in_ready, !in_ready, "block took a second word while busy")
  `BF_ASSERT_NEXT(a_count_mono, clk, rst, out_valid && out_ready, !out_valid || set_bit_count >= $past(set_bit_count) || $past(set_bit_count) == 21'h1FFFFF, "set bit count went down")
endmodule

bind bloom_filter_double_hash_core bfdh_checker u_bfdh_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .present(present),
  .set_bit_count(set_bit_count)
);

[sim/bloom_filter_double_hash_core_tb.sv]
module bloom_filter_double_hash_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run cap: clearing pass plus worst-case items (16 probes each),
  // long stalls on both sides, then several times over.
  localparam int CYCLE_LIMIT = 8000000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 44;
  localparam int DIR_ROWS    = 12;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                func = bfdh_pkg::FUNC_ADD;
  logic [63:0]         hash_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                present;
  logic [bfdh_pkg::CNT_W-1:0] set_bit_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = bfdh_pkg::REG_CAPACITY;
  logic [31:0]         cfg_data = '0;

  bloom_filter_double_hash_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .hash_value(hash_value),
    .out_valid(out_valid), .out_ready(out_ready), .present(present),
    .set_bit_count(set_bit_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one result word
  typedef struct packed {
    logic                       present;
    logic [bfdh_pkg::CNT_W-1:0] count;
  } result_word_t;

  // directed row; has_fixed marks rows whose result is typed in
  typedef struct {
    logic                       func;
    logic [63:0]                hash;
    bit                         has_fixed;
    logic                       present;
    logic [bfdh_pkg::CNT_W-1:0] count;
  } dir_row_t;

  // Reset config is capacity 1M, one probe; hash 0 probes bit 0,
  // all-ones probes 0xFFFFE, hi-only all-ones probes 0xFFFFF.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{bfdh_pkg::FUNC_LOOKUP, 64'h0,                  1'b1, 1'b0, 21'd0},
    '{bfdh_pkg::FUNC_ADD,    64'h0,                  1'b1, 1'b0, 21'd1},
    '{bfdh_pkg::FUNC_LOOKUP, 64'h0,                  1'b1, 1'b1, 21'd1},
    '{bfdh_pkg::FUNC_ADD,    64'hFFFFFFFF_FFFFFFFF,  1'b1, 1'b0, 21'd2},
    '{bfdh_pkg::FUNC_LOOKUP, 64'hFFFFFFFF_FFFFFFFF,  1'b1, 1'b1, 21'd2},
    '{bfdh_pkg::FUNC_LOOKUP, 64'h80000000_00000001,  1'b0, 1'b0, 21'd0},
    '{bfdh_pkg::FUNC_ADD,    64'hFFFFFFFF_00000000,  1'b1, 1'b0, 21'd3},
    '{bfdh_pkg::FUNC_ADD,    64'h00000000_FFFFFFFF,  1'b1, 1'b0, 21'd3},  // same bit again
    '{bfdh_pkg::FUNC_ADD,    64'h01234567_89ABCDEF,  1'b0, 1'b0, 21'd0},
    '{bfdh_pkg::FUNC_LOOKUP, 64'h01234567_89ABCDEF,  1'b0, 1'b0, 21'd0},
    '{bfdh_pkg::FUNC_LOOKUP, 64'h55555555_55555555,  1'b0, 1'b0, 21'd0},
    '{bfdh_pkg::FUNC_ADD,    64'hAAAAAAAA_AAAAAAAA,  1'b0, 1'b0, 21'd0}
  };

  // predictor state
  bit                          filter_bits [bfdh_pkg::FILTER_BITS];
  logic [bfdh_pkg::CNT_W-1:0]  ones_seen = '0;
  logic [bfdh_pkg::CAP_W-1:0]  cap_reg = 21'd1048576;
  logic [bfdh_pkg::HCNT_W-1:0] probes_reg = 5'd1;

  result_word_t predicted_words [$];
  logic [63:0]  added_hashes [$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           out_no_stall = 1'b0;
  int           out_stall_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Double-hash probe walk; updates the filter copy, returns the word.
  function automatic result_word_t bloom_predict(input logic op, input logic [63:0] h);
    logic [63:0]  hi_w, lo_w, probe, cap_w, pos;
    int           n;
    bit           all_set;
    result_word_t r;
    hi_w = {h[63:32], h[63:32]};
    lo_w = {h[31:0], h[31:0]};
    cap_w = (cap_reg == 0) ? 64'd1 :
            (cap_reg > bfdh_pkg::FILTER_BITS) ? 64'(bfdh_pkg::FILTER_BITS) : 64'(cap_reg);
    n = (probes_reg == 0) ? 1 :
        (probes_reg > bfdh_pkg::MAX_HASHES) ? bfdh_pkg::MAX_HASHES : int'(probes_reg);
    all_set = 1'b1;
    for (int k = 1; k <= n; k++) begin
      probe = hi_w + 64'(k) * lo_w;
      pos = probe % cap_w;
      if (!filter_bits[pos]) begin
        if (op == bfdh_pkg::FUNC_ADD) begin
          filter_bits[pos] = 1'b1;
          ones_seen = ones_seen + 1'b1;
        end else begin
          all_set = 1'b0;
        end
      end
    end
    r.present = (op == bfdh_pkg::FUNC_LOOKUP) && all_set;
    r.count = ones_seen;
    return r;
  endfunction

  // mostly zero, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // one input word; prediction taken at the accepting edge
  task automatic send_word(input logic op, input logic [63:0] h, input bit has_fixed,
                           input logic p, input logic [bfdh_pkg::CNT_W-1:0] c);
    result_word_t r;
    in_valid <= 1'b1;
    func <= op;
    hash_value <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = bloom_predict(op, h);
    if (has_fixed) begin
      r.present = p;
      r.count = c;
    end
    predicted_words.push_back(r);
    if (op == bfdh_pkg::FUNC_ADD) added_hashes.push_back(h);
  endtask

  // valid low for at least one edge
  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain, then settle before touching registers
  task automatic wait_drained();
    while (predicted_words.size() != 0) @(posedge clk);
    idle_cycles(8);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bfdh_pkg::REG_CAPACITY) cap_reg = data[bfdh_pkg::CAP_W-1:0];
    else probes_reg = data[bfdh_pkg::HCNT_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_hash();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30 && added_hashes.size() != 0)
      return added_hashes[$urandom_range(added_hashes.size() - 1)];
    if (roll < 38) return {32'($urandom_range(3)), 32'($urandom_range(3))};
    if (roll < 42) return ~64'h0 ^ 64'(1) << $urandom_range(63);
    return {$urandom, $urandom};
  endfunction

  // Result side: random stalls, with no-stall stretches.
  always @(posedge clk) begin
    if (out_no_stall || out_stall_left == 0) begin
      out_ready <= 1'b1;
      if (!out_no_stall && $urandom_range(99) < 20) out_stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end
  end

  // Result checker: compare each word against the oldest prediction.
  always @(posedge clk) begin
    result_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (predicted_words.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, present}, 32'd0);
      end else begin
        w = predicted_words.pop_front();
        if (present !== w.present)
          report_mismatch("present", 32'(present), 32'(w.present));
        if (set_bit_count !== w.count)
          report_mismatch("set_bit_count", 32'(set_bit_count), 32'(w.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // capacity and probe-count settings, in raw register terms
  logic [bfdh_pkg::CAP_W-1:0]  phase_cap    [RAND_PHASES] = '{
    21'd1048576, 21'd1, 21'd0, 21'd8, 21'd37, 21'h1FFFFF, 21'd1000, 21'd64, 21'd500, 21'd131
  };
  logic [bfdh_pkg::HCNT_W-1:0] phase_probes [RAND_PHASES] = '{
    5'd1, 5'd16, 5'd3, 5'd3, 5'd16, 5'd5, 5'd0, 5'd31, 5'd7, 5'd16
  };

  initial begin
    logic op;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows at reset config
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].func, dir_rows[i].hash, dir_rows[i].has_fixed,
                dir_rows[i].present, dir_rows[i].count);
      drop_valid();
      idle_cycles(pick_gap());
    end

    // random phases; capacity steps down leave bits set out of range
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      write_reg(bfdh_pkg::REG_CAPACITY, {11'($urandom), phase_cap[ph]});
      write_reg(bfdh_pkg::REG_HASH_COUNT, {27'($urandom), phase_probes[ph]});
      out_no_stall = (ph % 3 == 2);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        op = ($urandom_range(99) < 55) ? bfdh_pkg::FUNC_ADD : bfdh_pkg::FUNC_LOOKUP;
        send_word(op, pick_hash(), 1'b0, 1'b0, '0);
        if (!out_no_stall) begin
          // back-to-back words keep valid high
          if ($urandom_range(99) < 40) begin
            drop_valid();
            idle_cycles(pick_gap());
          end
        end
      end
      drop_valid();
    end
    out_no_stall = 1'b0;

    while (predicted_words.size() != 0) @(posedge clk);
    idle_cycles(50);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
